### rtl/core/three_body_acceleration_2d_top_assert.svh
// assertion macros for the three-body acceleration top level
// expects aclk and aresetn in the including scope
`ifndef THREE_BODY_ACCELERATION_2D_TOP_ASSERT_SVH
`define THREE_BODY_ACCELERATION_2D_TOP_ASSERT_SVH
// checked outside reset
`define TBA2D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked in every cycle, reset included
`define TBA2D_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`endif

### rtl/core/tba2d_pkg.sv
// shared widths, latencies, register indexes and types of the three-body block
// no dependencies
package tba2d_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 24;
    localparam int REG_W    = 31;
    localparam int IDX_W    = 3;
    localparam int DIF_W    = WORD_W + 1;
    localparam int SQ_W     = 2 * DIF_W;
    localparam int ROOT_W   = DIF_W;
    localparam int GM_W     = 2 * REG_W;
    localparam int GM_HALF  = REG_W;
    localparam int PP_W     = GM_HALF + DIF_W;
    localparam int NUM_W    = GM_W + DIF_W + FRAC_W;
    localparam int DEN_W    = 3 * ROOT_W;
    localparam int Q_W      = WORD_W;
    localparam int SUM_W    = DIF_W + 1;

    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int PAIR_LAT = 3 + SQRT_LAT + 3 + DIV_LAT;
    localparam int LAT      = PAIR_LAT + 2;

    localparam logic [REG_W-1:0]  REG_ONE  = REG_W'(64'd1 << FRAC_W);
    localparam logic [Q_W-1:0]    TERM_CAP = Q_W'(64'd1 << (WORD_W - 1));
    localparam logic [WORD_W-1:0] WORD_MAX = WORD_W'((64'd1 << (WORD_W - 1)) - 64'd1);
    localparam logic [WORD_W-1:0] WORD_MIN = WORD_W'(64'd1 << (WORD_W - 1));

    localparam logic [IDX_W-1:0] IDX_GRAV  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_MASS0 = 3'd1;
    localparam logic [IDX_W-1:0] IDX_MASS1 = 3'd2;
    localparam logic [IDX_W-1:0] IDX_MASS2 = 3'd3;

    typedef struct packed {
        logic signed [DIF_W-1:0] ca_x;
        logic signed [DIF_W-1:0] ca_y;
        logic signed [DIF_W-1:0] cb_x;
        logic signed [DIF_W-1:0] cb_y;
        logic                    flag;
    } pair_out_t;

endpackage

### rtl/core/tba2d_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on tba2d_pkg
module tba2d_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [tba2d_pkg::SQ_W-1:0]    sq,
    output logic [tba2d_pkg::ROOT_W-1:0]  root
);
    import tba2d_pkg::*;

    localparam int RW = SQ_W + 2;

    logic [RW-1:0]     rem_reg [ROOT_W];
    logic [ROOT_W-1:0] rt_reg  [ROOT_W];
    logic [RW-1:0]     rin     [ROOT_W];
    logic [ROOT_W-1:0] qin     [ROOT_W];
    logic [RW-1:0]     trial   [ROOT_W];

    always_comb begin
        rin[0] = RW'(sq);
        qin[0] = '0;
        for (int k = 1; k < ROOT_W; k++) begin
            rin[k] = rem_reg[k-1];
            qin[k] = rt_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            trial[k] = (RW'(qin[k]) << (ROOT_W - k)) + (RW'(1) << (2 * (ROOT_W - 1 - k)));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                if (rin[k] >= trial[k]) begin
                    rem_reg[k] <= rin[k] - trial[k];
                    rt_reg[k]  <= qin[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
                end else begin
                    rem_reg[k] <= rin[k];
                    rt_reg[k]  <= qin[k];
                end
            end
        end
    end

    assign root = rt_reg[ROOT_W-1];

endmodule

### rtl/core/tba2d_div.sv
// pipelined restoring divider, one quotient bit per stage, result limited to the term cap
// depends on tba2d_pkg
module tba2d_div (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [tba2d_pkg::NUM_W-1:0]  num,
    input  logic [tba2d_pkg::DEN_W-1:0]  den,
    output logic [tba2d_pkg::Q_W-1:0]    term
);
    import tba2d_pkg::*;

    localparam int CW = DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic             cap_reg [Q_W+1];
    logic [CW-1:0]    shd     [Q_W+1];
    logic             take    [Q_W+1];

    always_comb begin
        shd[0]  = '0;
        take[0] = 1'b0;
        for (int j = 1; j <= Q_W; j++) begin
            shd[j]  = CW'(den_reg[j-1]) << (Q_W - j);
            take[j] = CW'(rem_reg[j-1]) >= shd[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            cap_reg[0] <= CW'(num) >= (CW'(den) << Q_W);
            for (int j = 1; j <= Q_W; j++) begin
                den_reg[j] <= den_reg[j-1];
                cap_reg[j] <= cap_reg[j-1];
                if (take[j]) begin
                    rem_reg[j] <= rem_reg[j-1] - NUM_W'(shd[j]);
                    q_reg[j]   <= q_reg[j-1] | (Q_W'(1) << (Q_W - j));
                end else begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    assign term = (cap_reg[Q_W] || q_reg[Q_W] > TERM_CAP) ? TERM_CAP : q_reg[Q_W];

endmodule

### rtl/core/tba2d_pair.sv
// pull of one body pair: separation, length, cube, four saturated quotients
// depends on tba2d_pkg, tba2d_sqrt, tba2d_div
module tba2d_pair (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [tba2d_pkg::WORD_W-1:0] pa_x,
    input  logic signed [tba2d_pkg::WORD_W-1:0] pa_y,
    input  logic signed [tba2d_pkg::WORD_W-1:0] pb_x,
    input  logic signed [tba2d_pkg::WORD_W-1:0] pb_y,
    input  logic [tba2d_pkg::GM_W-1:0]          gm_pull_a,
    input  logic [tba2d_pkg::GM_W-1:0]          gm_pull_b,
    output tba2d_pkg::pair_out_t                res
);
    import tba2d_pkg::*;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } pair_ctl_t;

    typedef struct packed {
        logic [DIF_W-1:0] mag_x;
        logic [DIF_W-1:0] mag_y;
        logic [GM_W-1:0]  gm_a;
        logic [GM_W-1:0]  gm_b;
        pair_ctl_t        ctl;
    } pair_side_t;

    logic signed [DIF_W-1:0] dx, dy;
    pair_side_t              side_a;
    pair_side_t              side_a_reg, side_b_reg, side_c_reg;
    pair_side_t              side_dl [SQRT_LAT];
    pair_side_t              side_r1_reg;
    pair_ctl_t               ctl_r2_reg, ctl_r3_reg;
    pair_ctl_t               ctl_dl [DIV_LAT];
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, s_reg;
    logic [ROOT_W-1:0]       root, r1_reg;
    logic [SQ_W-1:0]         r2_reg, r3lo_reg, r3hi_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [GM_W-1:0]         gm_sel  [4];
    logic [DIF_W-1:0]        mag_sel [4];
    logic [PP_W-1:0]         pplo_reg [4];
    logic [PP_W-1:0]         pphi_reg [4];
    logic [NUM_W-1:0]        num_reg  [4];
    logic [NUM_W-1:0]        num3_reg [4];
    logic [Q_W-1:0]          term [4];
    pair_ctl_t               ctl_o;

    assign dx = DIF_W'(pb_x) - DIF_W'(pa_x);
    assign dy = DIF_W'(pb_y) - DIF_W'(pa_y);

    always_comb begin
        side_a.mag_x     = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
        side_a.mag_y     = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
        side_a.gm_a      = gm_pull_a;
        side_a.gm_b      = gm_pull_b;
        side_a.ctl.neg_x = dx[DIF_W-1];
        side_a.ctl.neg_y = dy[DIF_W-1];
        side_a.ctl.zero  = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg <= side_a;
            side_b_reg <= side_a_reg;
            sqx_reg    <= SQ_W'(side_a_reg.mag_x) * SQ_W'(side_a_reg.mag_x);
            sqy_reg    <= SQ_W'(side_a_reg.mag_y) * SQ_W'(side_a_reg.mag_y);
            side_c_reg <= side_b_reg;
            s_reg      <= sqx_reg + sqy_reg;
        end
    end

    tba2d_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .sq   (s_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dl[0] <= side_c_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                side_dl[i] <= side_dl[i-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            gm_sel[k]  = (k < 2) ? side_dl[SQRT_LAT-1].gm_a : side_dl[SQRT_LAT-1].gm_b;
            mag_sel[k] = (k % 2 == 1) ? side_dl[SQRT_LAT-1].mag_y : side_dl[SQRT_LAT-1].mag_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_r1_reg <= side_dl[SQRT_LAT-1];
            r1_reg      <= root;
            r2_reg      <= SQ_W'(root) * SQ_W'(root);
            for (int k = 0; k < 4; k++) begin
                pplo_reg[k] <= PP_W'(gm_sel[k][GM_HALF-1:0]) * PP_W'(mag_sel[k]);
                pphi_reg[k] <= PP_W'(gm_sel[k][GM_W-1:GM_HALF]) * PP_W'(mag_sel[k]);
            end
            ctl_r2_reg <= side_r1_reg.ctl;
            r3lo_reg   <= SQ_W'(r2_reg[ROOT_W-1:0]) * SQ_W'(r1_reg);
            r3hi_reg   <= SQ_W'(r2_reg[SQ_W-1:ROOT_W]) * SQ_W'(r1_reg);
            for (int k = 0; k < 4; k++) begin
                num_reg[k] <= ((NUM_W'(pphi_reg[k]) << GM_HALF) + NUM_W'(pplo_reg[k]))
                              << FRAC_W;
            end
            ctl_r3_reg <= ctl_r2_reg;
            den_reg    <= (DEN_W'(r3hi_reg) << ROOT_W) + DEN_W'(r3lo_reg);
            for (int k = 0; k < 4; k++) begin
                num3_reg[k] <= num_reg[k];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_div
        tba2d_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num3_reg[k]),
            .den  (den_reg),
            .term (term[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_dl[0] <= ctl_r3_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                ctl_dl[i] <= ctl_dl[i-1];
            end
        end
    end

    // term 0/1 pull body a along x/y, term 2/3 pull body b
    always_comb begin
        logic signed [DIF_W-1:0] t [4];
        ctl_o = ctl_dl[DIV_LAT-1];
        for (int k = 0; k < 4; k++) begin
            t[k] = $signed(DIF_W'(term[k]));
        end
        if (ctl_o.zero) begin
            res.ca_x = '0;
            res.ca_y = '0;
            res.cb_x = '0;
            res.cb_y = '0;
        end else begin
            res.ca_x = ctl_o.neg_x ? -t[0] : t[0];
            res.ca_y = ctl_o.neg_y ? -t[1] : t[1];
            res.cb_x = ctl_o.neg_x ? t[2] : -t[2];
            res.cb_y = ctl_o.neg_y ? t[3] : -t[3];
        end
        res.flag = ctl_o.zero || term[0] == TERM_CAP || term[1] == TERM_CAP
                   || term[2] == TERM_CAP || term[3] == TERM_CAP;
    end

endmodule

### rtl/core/three_body_acceleration_2d_top.sv
// top level of the planar three-body acceleration pipeline
// depends on tba2d_pkg, tba2d_pair, three_body_acceleration_2d_top_assert.svh
//
// channel  direction  payload
// s_       in         tdata: pos_x0 pos_y0 pos_x1 pos_y1 pos_x2 pos_y2, 32 bits each
// m_       out        tdata: acc_x0 .. acc_y2, 32 bits each; tuser: overflow_flag
// cfg_     in         index 0 gravity constant, 1..3 body masses
//
// one transaction per cycle, unless a result waiting on m_tready stalls the pipeline
// pipeline depth set by the 33-stage root and the 33-stage quotient units in each pair
// reset clears the valid bits and sets g and all masses to 1.0
// the whole pipeline holds while a result waits on m_tready low

module three_body_acceleration_2d_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [6*tba2d_pkg::WORD_W-1:0]    s_tdata,  // pos_x0 pos_y0 pos_x1 pos_y1 pos_x2 pos_y2
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [6*tba2d_pkg::WORD_W-1:0]    m_tdata,  // acc_x0 acc_y0 acc_x1 acc_y1 acc_x2 acc_y2
    output logic                              m_tuser,  // overflow_flag
    input  logic                              cfg_we,
    input  logic [tba2d_pkg::IDX_W-1:0]       cfg_index,
    input  logic [tba2d_pkg::REG_W-1:0]       cfg_wdata
);
    import tba2d_pkg::*;

    logic                     en;
    logic [LAT-1:0]           valid_reg;
    logic [REG_W-1:0]         g_reg;
    logic [REG_W-1:0]         mass_reg [3];
    logic signed [WORD_W-1:0] pos_reg  [6];
    logic [GM_W-1:0]          gm_reg   [3];
    pair_out_t                p01, p02, p12;
    logic signed [SUM_W-1:0]  sum      [6];
    logic [WORD_W-1:0]        acc_next [6];
    logic                     sat      [6];
    logic                     flag_next;
    logic [WORD_W-1:0]        acc_reg  [6];
    logic                     flag_reg;

    assign en       = m_tready || !valid_reg[LAT-1];
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg       <= REG_ONE;
            mass_reg[0] <= REG_ONE;
            mass_reg[1] <= REG_ONE;
            mass_reg[2] <= REG_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                IDX_GRAV:  g_reg       <= cfg_wdata;
                IDX_MASS0: mass_reg[0] <= cfg_wdata;
                IDX_MASS1: mass_reg[1] <= cfg_wdata;
                IDX_MASS2: mass_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                pos_reg[i] <= $signed(s_tdata[i*WORD_W +: WORD_W]);
            end
            for (int j = 0; j < 3; j++) begin
                gm_reg[j] <= GM_W'(g_reg) * GM_W'(mass_reg[j]);
            end
        end
    end

    tba2d_pair u_pair01 (
        .aclk (aclk), .en (en),
        .pa_x (pos_reg[0]), .pa_y (pos_reg[1]), .pb_x (pos_reg[2]), .pb_y (pos_reg[3]),
        .gm_pull_a (gm_reg[1]), .gm_pull_b (gm_reg[0]), .res (p01)
    );

    tba2d_pair u_pair02 (
        .aclk (aclk), .en (en),
        .pa_x (pos_reg[0]), .pa_y (pos_reg[1]), .pb_x (pos_reg[4]), .pb_y (pos_reg[5]),
        .gm_pull_a (gm_reg[2]), .gm_pull_b (gm_reg[0]), .res (p02)
    );

    tba2d_pair u_pair12 (
        .aclk (aclk), .en (en),
        .pa_x (pos_reg[2]), .pa_y (pos_reg[3]), .pb_x (pos_reg[4]), .pb_y (pos_reg[5]),
        .gm_pull_a (gm_reg[2]), .gm_pull_b (gm_reg[1]), .res (p12)
    );

    always_comb begin
        sum[0] = SUM_W'(p01.ca_x) + SUM_W'(p02.ca_x);
        sum[1] = SUM_W'(p01.ca_y) + SUM_W'(p02.ca_y);
        sum[2] = SUM_W'(p01.cb_x) + SUM_W'(p12.ca_x);
        sum[3] = SUM_W'(p01.cb_y) + SUM_W'(p12.ca_y);
        sum[4] = SUM_W'(p02.cb_x) + SUM_W'(p12.cb_x);
        sum[5] = SUM_W'(p02.cb_y) + SUM_W'(p12.cb_y);
        flag_next = p01.flag || p02.flag || p12.flag;
        for (int i = 0; i < 6; i++) begin
            sat[i] = !((sum[i][SUM_W-1:WORD_W-1] == '0)
                       || (sum[i][SUM_W-1:WORD_W-1] == '1));
            if (sat[i]) begin
                acc_next[i] = sum[i][SUM_W-1] ? WORD_MIN : WORD_MAX;
            end else begin
                acc_next[i] = sum[i][WORD_W-1:0];
            end
            flag_next = flag_next || sat[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                acc_reg[i] <= acc_next[i];
            end
            flag_reg <= flag_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m_tdata[i*WORD_W +: WORD_W] = acc_reg[i];
        end
    end
    assign m_tuser = flag_reg;

`include "three_body_acceleration_2d_top_assert.svh"

    `TBA2D_ASSERT(a_hold_on_stall, !en |=> $stable(valid_reg), "valid bits moved during stall")
    `TBA2D_ASSERT(a_valid_advance, en |=> (m_tvalid == $past(valid_reg[LAT-2])), "valid lost")
    `TBA2D_ASSERT_RST(a_reset_empty, !aresetn |=> (valid_reg == '0), "pipeline not empty")

endmodule

### verif/tb_top.sv
// self-checking testbench for three_body_acceleration_2d_top: positions in, accelerations out
// predicts untyped results with its own fixed-point acceleration model; depends on tba2d_pkg
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tba2d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = LAT + 20;
    localparam int RAND_ITEMS  = 1680;
    localparam logic [63:0] TOP = 64'd1 << (WORD_W - 1);

    typedef struct {
        logic [6*WORD_W-1:0] acc;
        logic                flag;
    } accel_t;

    typedef struct {
        logic [6*WORD_W-1:0] pos;
        bit                  typed;
        logic [6*WORD_W-1:0] acc;
        logic                flag;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [6*WORD_W-1:0]      s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [6*WORD_W-1:0]      m_tdata;
    logic                     m_tuser;
    logic                     cfg_we;
    logic [IDX_W-1:0]         cfg_index;
    logic [REG_W-1:0]         cfg_wdata;

    logic [REG_W-1:0] grav_reg;
    logic [REG_W-1:0] mass_reg [3];
    accel_t           accel_q [$];
    int               errors;
    int               cycles;
    int               send_idle;
    int               recv_idle;

    three_body_acceleration_2d_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] isqrt(logic [127:0] val);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= val)
                root = cand;
        end
        return root;
    endfunction

    function automatic logic [63:0] pull_term(logic [REG_W-1:0] m, logic [63:0] mag,
                                              logic [127:0] r3);
        logic [127:0] q;
        q = ((128'(grav_reg) * 128'(m) * 128'(mag)) << FRAC_W) / r3;
        return (q > 128'(TOP)) ? TOP : q[63:0];
    endfunction

    function automatic accel_t predict_accel(logic [6*WORD_W-1:0] pos);
        int                 pa [3] = '{0, 0, 1};
        int                 pb [3] = '{1, 2, 2};
        logic signed [63:0] p [6];
        logic signed [63:0] acc [6];
        logic signed [63:0] d [2];
        logic [63:0]        mag [2];
        logic [63:0]        r;
        logic [63:0]        ta;
        logic [63:0]        tb;
        logic [127:0]       r3;
        accel_t             res;
        res.flag = 1'b0;
        for (int i = 0; i < 6; i++) begin
            p[i] = $signed(pos[WORD_W*i +: WORD_W]);
            acc[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 2; c++) begin
                d[c] = p[2*pb[i]+c] - p[2*pa[i]+c];
                mag[c] = d[c] < 0 ? -d[c] : d[c];
            end
            r = isqrt(128'(mag[0]) * 128'(mag[0]) + 128'(mag[1]) * 128'(mag[1]));
            if (r == 0) begin
                res.flag = 1'b1;
                continue;
            end
            r3 = 128'(r) * 128'(r) * 128'(r);
            for (int c = 0; c < 2; c++) begin
                ta = pull_term(mass_reg[pb[i]], mag[c], r3);
                tb = pull_term(mass_reg[pa[i]], mag[c], r3);
                if (ta >= TOP || tb >= TOP)
                    res.flag = 1'b1;
                if (d[c] < 0) begin
                    acc[2*pa[i]+c] -= $signed(ta);
                    acc[2*pb[i]+c] += $signed(tb);
                end else begin
                    acc[2*pa[i]+c] += $signed(ta);
                    acc[2*pb[i]+c] -= $signed(tb);
                end
            end
        end
        for (int i = 0; i < 6; i++) begin
            if (acc[i] > $signed(TOP - 1)) begin
                acc[i] = TOP - 1;
                res.flag = 1'b1;
            end
            if (acc[i] < -$signed(TOP)) begin
                acc[i] = -$signed(TOP);
                res.flag = 1'b1;
            end
            res.acc[WORD_W*i +: WORD_W] = acc[i][WORD_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // caller sits at a falling edge
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            IDX_GRAV: grav_reg = val;
            IDX_MASS0: mass_reg[0] = val;
            IDX_MASS1: mass_reg[1] = val;
            IDX_MASS2: mass_reg[2] = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_positions(logic [6*WORD_W-1:0] pos, bit typed, accel_t fixed);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pos;
        @(posedge aclk iff (s_tvalid && s_tready));
        accel_q.push_back(typed ? fixed : predict_accel(pos));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (accel_q.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic logic [6*WORD_W-1:0] random_positions();
        logic [6*WORD_W-1:0] pos;
        logic [31:0]         base;
        int                  kind;
        kind = $urandom_range(9);
        base = $urandom;
        for (int i = 0; i < 6; i++) begin
            if (kind < 3)
                pos[WORD_W*i +: WORD_W] = $urandom;
            else if (kind < 8)
                pos[WORD_W*i +: WORD_W] = base + (($urandom >> $urandom_range(31)) ^
                                                  ($urandom_range(1) ? 32'hffffffff : 0));
            else
                pos[WORD_W*i +: WORD_W] = base + $urandom_range(255) - 128;
        end
        // occasional coincident pair
        if ($urandom_range(15) == 0)
            pos[64 +: 64] = pos[0 +: 64];
        if ($urandom_range(15) == 0)
            pos[128 +: 64] = pos[64 +: 64];
        return pos;
    endfunction

    function automatic logic [6*WORD_W-1:0] pack6(logic [31:0] x0, logic [31:0] y0,
                                                 logic [31:0] x1, logic [31:0] y1,
                                                 logic [31:0] x2, logic [31:0] y2);
        return {y2, x2, y1, x1, y0, x0};
    endfunction

    always @(posedge aclk) begin
        accel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (accel_q.size() == 0) begin
                $display("unexpected result transaction at cycle %0d", cycles);
                errors++;
            end else begin
                want = accel_q.pop_front();
                for (int i = 0; i < 6; i++)
                    if (m_tdata[WORD_W*i +: WORD_W] !== want.acc[WORD_W*i +: WORD_W])
                        report_mismatch($sformatf("acc field %0d", i),
                                        64'(m_tdata[WORD_W*i +: WORD_W]),
                                        64'(want.acc[WORD_W*i +: WORD_W]));
                if (m_tuser !== want.flag)
                    report_mismatch("overflow_flag", 64'(m_tuser), 64'(want.flag));
            end
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("three_body_acceleration_2d_top regression: fail");
            $finish;
        end
    end

    initial begin
        stim_row_t        rows [$];
        stim_row_t        row;
        accel_t           fixed;
        logic [REG_W-1:0] reg_max;
        int               pct_send [3];
        int               pct_recv [3];
        pct_send = '{29, 77, 0};
        pct_recv = '{77, 29, 0};
        errors = 0;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        grav_reg = REG_ONE;
        mass_reg = '{REG_ONE, REG_ONE, REG_ONE};
        reg_max = '1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // all bodies coincide
        rows.push_back('{pack6(0, 0, 0, 0, 0, 0), 1, '0, 1'b1});
        // collinear at 0, 1.0, 2.0 with unit g and masses
        rows.push_back('{pack6(0, 0, 32'h01000000, 0, 32'h02000000, 0), 1,
                         {32'h0, 32'hfec00000, 32'h0, 32'h0, 32'h0, 32'h01400000}, 1'b0});
        // one coincident pair
        rows.push_back('{pack6(32'h01000000, 32'h01000000, 32'h01000000, 32'h01000000,
                               32'hff000000, 32'h00800000), 0, '0, 0});
        // position extremes
        rows.push_back('{pack6(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff), 0, '0, 0});
        rows.push_back('{pack6(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                               0, 0), 0, '0, 0});
        // closest distinct bodies, large pull terms
        rows.push_back('{pack6(0, 0, 1, 0, 0, 1), 0, '0, 0});
        rows.push_back('{pack6(32'hffffffff, 32'hffffffff, 0, 0, 1, 1), 0, '0, 0});
        rows.push_back('{pack6(5, 7, 5, 8, 32'h40000000, 32'hc0000000), 0, '0, 0});
        for (int i = 0; i < rows.size(); i++) begin
            fixed.acc = rows[i].acc;
            fixed.flag = rows[i].flag;
            send_positions(rows[i].pos, rows[i].typed, fixed);
        end
        drain();

        // register extremes on a few directed positions
        write_reg(IDX_GRAV, reg_max);
        write_reg(IDX_MASS0, reg_max);
        write_reg(IDX_MASS1, '0);
        write_reg(IDX_MASS2, REG_ONE);
        write_reg(3'd5, 31'h12345);
        for (int i = 2; i < rows.size(); i++)
            send_positions(rows[i].pos, 0, fixed);
        send_positions(pack6(0, 0, 32'h10000000, 0, 0, 32'h10000000), 0, fixed);
        drain();
        write_reg(IDX_GRAV, '0);
        for (int i = 2; i < 5; i++)
            send_positions(rows[i].pos, 0, fixed);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = pct_send[ph];
            recv_idle = pct_recv[ph];
            for (int k = 0; k < 4; k++) begin
                drain();
                case (k)
                    0: begin
                        write_reg(IDX_GRAV, REG_ONE);
                        write_reg(IDX_MASS0, REG_ONE);
                        write_reg(IDX_MASS1, REG_ONE);
                        write_reg(IDX_MASS2, REG_ONE);
                    end
                    1: begin
                        write_reg(IDX_GRAV, reg_max);
                        write_reg(IDX_MASS0, reg_max);
                        write_reg(IDX_MASS1, reg_max);
                        write_reg(IDX_MASS2, reg_max);
                    end
                    default: begin
                        write_reg(IDX_GRAV, REG_W'($urandom >> $urandom_range(31)));
                        write_reg(IDX_MASS0, REG_W'($urandom >> $urandom_range(31)));
                        write_reg(IDX_MASS1, REG_W'($urandom >> $urandom_range(31)));
                        write_reg(IDX_MASS2, REG_W'($urandom >> $urandom_range(31)));
                        write_reg(IDX_W'($urandom_range(7, 4)), REG_W'($urandom));
                    end
                endcase
                for (int n = 0; n < RAND_ITEMS / 12; n++)
                    send_positions(random_positions(), 0, fixed);
            end
        end
        s_tvalid <= 1'b0;
        wait (accel_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && accel_q.size() == 0) begin
            $display("three_body_acceleration_2d_top regression: pass");
        end else begin
            $display("three_body_acceleration_2d_top regression: fail");
        end
        $finish;
    end
endmodule
